// ----- rtl/d2q_pkg.sv -----
package d2q_pkg;

  // candidate width: 1 + 2*c - trace stays well inside 36 signed bits
  localparam int PW = 36;
  // numerator width: sum or difference of two elements
  localparam int NW = 34;
  // numerator magnitude width
  localparam int MW = 33;
  // radicand and dividend width
  localparam int RW = 64;
  localparam int QW = 32;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_t;

  typedef struct packed {
    logic signed [31:0] c00;
    logic signed [31:0] c01;
    logic signed [31:0] c02;
    logic signed [31:0] c10;
    logic signed [31:0] c11;
    logic signed [31:0] c12;
    logic signed [31:0] c20;
    logic signed [31:0] c21;
    logic signed [31:0] c22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               invalid;
  } out_t;

  // classified item: root selection, radicand and the three numerators in
  // increasing component order with the root component left out
  typedef struct packed {
    sel_t                  sel;
    logic                  invalid;
    logic [RW-1:0]         rad;
    logic [2:0]            nsgn;
    logic [2:0][MW-1:0]    nmag;
  } wrk_t;

  // signed saturation of a sign and magnitude; big marks a magnitude of 2^32 or more
  function automatic logic [31:0] sat_mag(input logic neg, input logic big,
                                          input logic [31:0] m);
    logic [31:0] r;
    if (!neg) begin
      r = (big || m[31]) ? 32'h7fff_ffff : m;
    end else begin
      r = (big || m[31]) ? 32'h8000_0000 : (32'd0 - m);
    end
    return r;
  endfunction

endpackage

// ----- rtl/d2q_front.sv -----
module d2q_front #(
  parameter int FRAC_BITS = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  d2q_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  output d2q_pkg::wrk_t wrk,
  output logic          wrk_valid,
  input  logic          wrk_ready
);

  localparam int PW = d2q_pkg::PW;
  localparam int NW = d2q_pkg::NW;
  localparam int MW = d2q_pkg::MW;
  localparam int RW = d2q_pkg::RW;

  logic                 adv;
  logic                 v1;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [NW-1:0] n_12m21, n_20m02, n_01m10, n_01p10, n_02p20, n_12p21;

  logic signed [PW-1:0] one;
  logic signed [PW-1:0] tr;
  logic signed [PW-1:0] e00, e11, e22;

  d2q_pkg::wrk_t        wrk_next;
  logic signed [PW-1:0] p_sel;
  logic signed [NW-1:0] n0, n1, n2;

  assign adv      = !wrk_valid || wrk_ready;
  assign in_ready = adv;

  assign one = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
  assign e00 = PW'(in_data.c00);
  assign e11 = PW'(in_data.c11);
  assign e22 = PW'(in_data.c22);
  assign tr  = e00 + e11 + e22;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1      <= one + tr;
      p2      <= one + (e00 <<< 1) - tr;
      p3      <= one + (e11 <<< 1) - tr;
      p4      <= one + (e22 <<< 1) - tr;
      n_12m21 <= NW'(in_data.c12) - NW'(in_data.c21);
      n_20m02 <= NW'(in_data.c20) - NW'(in_data.c02);
      n_01m10 <= NW'(in_data.c01) - NW'(in_data.c10);
      n_01p10 <= NW'(in_data.c01) + NW'(in_data.c10);
      n_02p20 <= NW'(in_data.c02) + NW'(in_data.c20);
      n_12p21 <= NW'(in_data.c12) + NW'(in_data.c21);
    end
  end

  // pick the largest candidate, earlier one on a tie
  always_comb begin
    if (p1 >= p2 && p1 >= p3 && p1 >= p4) begin
      wrk_next.sel = d2q_pkg::SEL_W;
      p_sel        = p1;
    end else if (p2 >= p3 && p2 >= p4) begin
      wrk_next.sel = d2q_pkg::SEL_X;
      p_sel        = p2;
    end else if (p3 >= p4) begin
      wrk_next.sel = d2q_pkg::SEL_Y;
      p_sel        = p3;
    end else begin
      wrk_next.sel = d2q_pkg::SEL_Z;
      p_sel        = p4;
    end

    unique case (wrk_next.sel)
      d2q_pkg::SEL_W: begin
        n0 = n_12m21; n1 = n_20m02; n2 = n_01m10;
      end
      d2q_pkg::SEL_X: begin
        n0 = n_12m21; n1 = n_01p10; n2 = n_02p20;
      end
      d2q_pkg::SEL_Y: begin
        n0 = n_20m02; n1 = n_01p10; n2 = n_12p21;
      end
      default: begin
        n0 = n_01m10; n1 = n_02p20; n2 = n_12p21;
      end
    endcase

    wrk_next.invalid = p_sel[PW-1] || (p_sel == '0);
    wrk_next.rad     = RW'(p_sel[PW-2:0]) << (FRAC_BITS - 2);
    wrk_next.nsgn    = {n2[NW-1], n1[NW-1], n0[NW-1]};
    wrk_next.nmag[0] = n0[NW-1] ? MW'(-n0) : MW'(n0);
    wrk_next.nmag[1] = n1[NW-1] ? MW'(-n1) : MW'(n1);
    wrk_next.nmag[2] = n2[NW-1] ? MW'(-n2) : MW'(n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrk_valid <= 1'b0;
    end else if (adv) begin
      wrk_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wrk <= wrk_next;
    end
  end

endmodule

// ----- rtl/d2q_fifo.sv -----
module d2q_fifo (
  input  logic          clk,
  input  logic          rst,
  input  d2q_pkg::wrk_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output d2q_pkg::wrk_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);

  localparam int DEPTH = d2q_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  d2q_pkg::wrk_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/d2q_back.sv -----
module d2q_back #(
  parameter int FRAC_BITS = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  d2q_pkg::wrk_t wrk,
  input  logic          wrk_valid,
  output logic          wrk_ready,
  output d2q_pkg::out_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);

  localparam int MW = d2q_pkg::MW;
  localparam int RW = d2q_pkg::RW;
  localparam int QW = d2q_pkg::QW;
  localparam int SQ = QW;       // one root bit per stage
  localparam int DV = MW;       // quotient bits 32 down to 0
  localparam int DW = QW + 2;   // divisor 4*root
  localparam int XW = RW + 4;

  typedef struct packed {
    d2q_pkg::sel_t      sel;
    logic               invalid;
    logic [2:0]         nsgn;
    logic [2:0][MW-1:0] nmag;
    logic [QW+2:0]      rem;
    logic [QW-1:0]      root;
    logic [RW-1:0]      rad;
  } sq_t;

  typedef struct packed {
    d2q_pkg::sel_t      sel;
    logic               invalid;
    logic [2:0]         nsgn;
    logic [QW-1:0]      root;
    logic [DW-1:0]      den;
    logic [2:0]         ovf;
    logic [2:0][RW-1:0] rem;
    logic [2:0][MW-1:0] quo;
  } dv_t;

  logic adv;
  logic sq_v [SQ+1];
  sq_t  sq   [SQ+1];
  logic dv_v [DV+1];
  dv_t  dv   [DV+1];
  dv_t  dv_init;

  assign adv       = !out_valid || out_ready;
  assign wrk_ready = adv;

  // capture from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= wrk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].sel     <= wrk.sel;
      sq[0].invalid <= wrk.invalid;
      sq[0].nsgn    <= wrk.nsgn;
      sq[0].nmag    <= wrk.nmag;
      sq[0].rem     <= '0;
      sq[0].root    <= '0;
      sq[0].rad     <= wrk.rad;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [QW+2:0] rn;
    logic [QW+2:0] trial;
    sq_t           nxt;

    always_comb begin
      nxt   = sq[k];
      rn    = {sq[k].rem[QW:0], sq[k].rad[RW-1:RW-2]};
      trial = {1'b0, sq[k].root, 2'b01};
      if (rn >= trial) begin
        nxt.rem  = rn - trial;
        nxt.root = {sq[k].root[QW-2:0], 1'b1};
      end else begin
        nxt.rem  = rn;
        nxt.root = {sq[k].root[QW-2:0], 1'b0};
      end
      nxt.rad = sq[k].rad << 2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k+1] <= nxt;
      end
    end
  end

  // dividend = |n| * 2^F + 2*root for round half away from zero
  always_comb begin
    dv_init.sel     = sq[SQ].sel;
    dv_init.invalid = sq[SQ].invalid;
    dv_init.nsgn    = sq[SQ].nsgn;
    dv_init.root    = sq[SQ].root;
    dv_init.den     = {sq[SQ].root, 2'b00};
    for (int l = 0; l < 3; l++) begin
      dv_init.rem[l] = (RW'(sq[SQ].nmag[l]) << FRAC_BITS)
                       + RW'({sq[SQ].root, 1'b0});
      dv_init.ovf[l] = (dv_init.rem[l] >> DV) >= RW'(dv_init.den);
      dv_init.quo[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv_init;
    end
  end

  // restoring division, quotient bit DV-1-j at stage j
  for (genvar j = 0; j < DV; j++) begin : g_dv
    logic [XW-1:0] sub;
    dv_t           nxt;

    assign sub = XW'(dv[j].den) << (DV - 1 - j);

    always_comb begin
      nxt = dv[j];
      for (int l = 0; l < 3; l++) begin
        if (XW'(dv[j].rem[l]) >= sub) begin
          nxt.rem[l]           = dv[j].rem[l] - RW'(sub);
          nxt.quo[l][DV-1-j]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1] <= nxt;
      end
    end
  end

  // place components, flip so the scalar part is not negative, saturate; an invalid item gives zeros
  dv_t           fin;
  logic          flip;
  logic [2:0]    big;
  logic [2:0]    lneg;
  logic [2:0][31:0] lval;
  logic [31:0]   rval;
  d2q_pkg::out_t res;

  assign fin = dv[DV];

  always_comb begin
    flip = (fin.sel != d2q_pkg::SEL_W) && fin.nsgn[0]
           && (fin.ovf[0] || (fin.quo[0] != '0));
    for (int l = 0; l < 3; l++) begin
      big[l]  = fin.ovf[l] || fin.quo[l][MW-1];
      lneg[l] = fin.nsgn[l] ^ flip;
      lval[l] = d2q_pkg::sat_mag(lneg[l], big[l], fin.quo[l][31:0]);
    end
    rval = d2q_pkg::sat_mag(flip, 1'b0, fin.root);

    unique case (fin.sel)
      d2q_pkg::SEL_W: begin
        res.quat_w = rval;    res.quat_x = lval[0];
        res.quat_y = lval[1]; res.quat_z = lval[2];
      end
      d2q_pkg::SEL_X: begin
        res.quat_w = lval[0]; res.quat_x = rval;
        res.quat_y = lval[1]; res.quat_z = lval[2];
      end
      d2q_pkg::SEL_Y: begin
        res.quat_w = lval[0]; res.quat_x = lval[1];
        res.quat_y = rval;    res.quat_z = lval[2];
      end
      default: begin
        res.quat_w = lval[0]; res.quat_x = lval[1];
        res.quat_y = lval[2]; res.quat_z = rval;
      end
    endcase
    res.invalid = fin.invalid;
    if (fin.invalid) begin
      res.quat_w = '0;
      res.quat_x = '0;
      res.quat_y = '0;
      res.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule

// ----- rtl/dcm_to_quaternion.sv -----
// Throughput: one matrix per cycle when the output side keeps taking items.
// Depth: an item passes 71 register stages (2 classify, 1 queue slot,
//   33 square root, 34 divide, 1 output), and the first classify stage
//   loads on the accepting edge. One root bit and one quotient bit per
//   stage set the depth.
// Reset: synchronous rst clears all valid flags and queue pointers; data
//   registers are not reset.
module dcm_to_quaternion #(
  parameter int FRAC_BITS = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  d2q_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  output d2q_pkg::out_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);

  d2q_pkg::wrk_t f_wrk;
  logic          f_valid;
  logic          f_ready;
  d2q_pkg::wrk_t b_wrk;
  logic          b_valid;
  logic          b_ready;

  d2q_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .wrk      (f_wrk),
    .wrk_valid(f_valid),
    .wrk_ready(f_ready)
  );

  d2q_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_data (f_wrk),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .rd_data (b_wrk),
    .rd_valid(b_valid),
    .rd_ready(b_ready)
  );

  d2q_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wrk      (b_wrk),
    .wrk_valid(b_valid),
    .wrk_ready(b_ready),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule
